[rtl/fire_effect_heat_engine_top_assert.svh]
// Assertion macros for the fire heat engine RTL.
`ifndef FIRE_EFFECT_HEAT_ENGINE_TOP_ASSERT_SVH
`define FIRE_EFFECT_HEAT_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FEH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FEH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/feh_pkg.sv]
// Types and constants of the fire heat engine.
package feh_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_SEED = 6'b000100,
    ST_PRE  = 6'b001000,
    ST_LOAD = 6'b010000,
    ST_RUN  = 6'b100000
  } state_t;

  // Item kinds.
  localparam logic KIND_ADVANCE = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  // Random generator and cooling constants.
  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_ADD   = 32'd1013904223;
  localparam logic [31:0] RNG_RESET = 32'd12345;
  localparam logic [7:0]  COOLING   = 8'd4;

  // Black-red-yellow-white ramp packed as RGB565.
  function automatic logic [15:0] heat_colour(input logic [7:0] h);
    logic [15:0] c;
    case (h[7:6])
      2'd0:    c = {h[5:1], 11'd0};
      2'd1:    c = {5'h1f, h[5:0], 5'd0};
      2'd2:    c = {5'h1f, 6'h3f, h[5:1]};
      default: c = 16'hffff;
    endcase
    return c;
  endfunction

endpackage

[rtl/fire_effect_heat_engine_top.sv]
// Fire heat engine: heat grid memory, seed generator and row-update sequencer.
`include "fire_effect_heat_engine_top_assert.svh"

// A read item is one memory read, then the result lands in the output
// register. An advance item seeds both bottom rows, two cells per column,
// then updates each remaining row cell by cell through the single averaging
// unit, after the ST_PRE and ST_LOAD states prefetch the wrapped neighbors
// of that row. The grid memory has one write port. No input is taken while
// an item is in work. The grid needs no clearing pass after reset: until the
// first advance has finished, cells that it has not yet written read as zero.
module fire_effect_heat_engine_top #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 42
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  column,
  input  logic [5:0]  line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  heat,
  output logic [15:0] colour,
  output logic        visible
);
  import feh_pkg::*;

  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);

  state_t         state;
  state_t         state_next;
  logic [XW-1:0]  x;
  logic [YW-1:0]  y;
  logic           seed_hi;
  logic           frame_done;
  logic [31:0]    rng;
  logic [31:0]    rng_next;
  logic [7:0]     left_w;
  logic [7:0]     center_w;
  logic           rd_oob;
  logic           rd_ok;

  logic [7:0]     grid_mem [DEPTH];
  logic [AW-1:0]  rd_a_addr;
  logic [AW-1:0]  rd_b_addr;
  logic [7:0]     rd_a_data;
  logic [7:0]     rd_b_data;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;

  logic           in_accept;
  logic           below_ok;
  logic           below2_ok;
  logic [XW-1:0]  ic;
  logic [XW:0]    rc_sum;
  logic [XW-1:0]  rc;
  logic [7:0]     a_val;
  logic [7:0]     b_val;
  logic [9:0]     sum;
  logic [7:0]     avg;
  logic [7:0]     cell_new;
  logic           last_col;
  logic           last_row;

  // Linear address of a cell.
  function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] r,
                                               input logic [AW-1:0] c);
    return AW'(r * AW'(GRID_WIDTH) + c);
  endfunction

  // Handshake on the input side; a read waits while a result is still held.
  assign in_stall  = (state != ST_IDLE) || (out_valid && out_stall && (kind == KIND_READ));
  assign in_accept = in_valid && !in_stall;

  assign last_col = (x == XW'(GRID_WIDTH - 1));
  assign last_row = (y == YW'(GRID_HEIGHT - 3));

  // Rows not yet written since reset read as zero.
  assign below_ok  = frame_done || (32'(y) + 32'd1 >= 32'(GRID_HEIGHT - 2));
  assign below2_ok = frame_done || (32'(y) + 32'd2 >= 32'(GRID_HEIGHT - 2));

  // Column being fetched and its right neighbor with wraparound.
  assign ic     = (state == ST_RUN) ? XW'(x + XW'(1)) : '0;
  assign rc_sum = {1'b0, ic} + (XW + 1)'(1);
  assign rc     = (32'(rc_sum) >= GRID_WIDTH) ? XW'(rc_sum - (XW + 1)'(GRID_WIDTH))
                                              : XW'(rc_sum);

  // Generator step.
  assign rng_next = rng * LCG_MUL + LCG_ADD;

  // Shared averaging and cooling unit.
  assign a_val    = below_ok ? rd_a_data : 8'd0;
  assign b_val    = below2_ok ? rd_b_data : 8'd0;
  assign sum      = 10'(left_w) + 10'(center_w) + 10'(a_val) + 10'(b_val);
  assign avg      = sum[9:2];
  assign cell_new = (avg > COOLING) ? avg - COOLING : 8'd0;

  // Read port addresses.
  always_comb begin
    case (state)
      ST_PRE: begin
        rd_a_addr = cell_addr(AW'(y) + AW'(1), AW'(GRID_WIDTH - 1));
        rd_b_addr = cell_addr(AW'(y) + AW'(1), '0);
      end
      ST_LOAD, ST_RUN: begin
        rd_a_addr = cell_addr(AW'(y) + AW'(1), AW'(rc));
        rd_b_addr = cell_addr(AW'(y) + AW'(2), AW'(ic));
      end
      default: begin
        rd_a_addr = cell_addr(AW'(line), AW'(column));
        rd_b_addr = '0;
      end
    endcase
  end

  // Write port: seed bytes, then updated cells.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cell_addr(AW'(y), AW'(x));
    wr_data = cell_new;
    case (state)
      ST_SEED: begin
        wr_en   = 1'b1;
        wr_addr = cell_addr(seed_hi ? AW'(GRID_HEIGHT - 2) : AW'(GRID_HEIGHT - 1), AW'(x));
        wr_data = rng_next[23:16];
      end
      ST_RUN: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Heat grid memory with registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    rd_a_data <= grid_mem[rd_a_addr];
    rd_b_data <= grid_mem[rd_b_addr];
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (kind == KIND_READ) ? ST_READ : ST_SEED;
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_SEED: begin
        if (seed_hi && last_col) begin
          state_next = ST_PRE;
        end
      end
      ST_PRE:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_RUN;
      ST_RUN: begin
        if (last_col) begin
          state_next = last_row ? ST_IDLE : ST_PRE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer registers and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      x          <= '0;
      y          <= '0;
      seed_hi    <= 1'b0;
      frame_done <= 1'b0;
      rng        <= RNG_RESET;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          x       <= '0;
          y       <= '0;
          seed_hi <= 1'b0;
        end
        ST_SEED: begin
          rng     <= rng_next;
          seed_hi <= !seed_hi;
          if (seed_hi) begin
            x <= last_col ? '0 : x + XW'(1);
          end
        end
        ST_RUN: begin
          if (last_col) begin
            x <= '0;
            if (last_row) begin
              frame_done <= 1'b1;
            end else begin
              y <= y + YW'(1);
            end
          end else begin
            x <= x + XW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Neighbor window along the row below.
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        left_w   <= below_ok ? rd_a_data : 8'd0;
        center_w <= below_ok ? rd_b_data : 8'd0;
      end
      ST_RUN: begin
        left_w   <= center_w;
        center_w <= a_val;
      end
      default: begin
      end
    endcase
  end

  // Read item qualifiers, held for the data cycle. A read returns zero
  // before the first advance has finished.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rd_oob <= (32'(line) >= GRID_HEIGHT) || (32'(column) >= GRID_WIDTH);
      rd_ok  <= frame_done;
    end
  end

  // Output register for the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_READ) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      if (rd_oob || !rd_ok) begin
        heat    <= 8'd0;
        colour  <= 16'd0;
        visible <= 1'b0;
      end else begin
        heat    <= rd_a_data;
        colour  <= heat_colour(rd_a_data);
        visible <= (rd_a_data != 8'd0);
      end
    end
  end

  // Checks on the sequencer.
  `FEH_ASSERT_NEXT(a_read_goes_to_data, clk, rst, in_accept && (kind == KIND_READ), state == ST_READ, "read word did not reach the data cycle")
  `FEH_ASSERT_NOW(a_result_from_read, clk, rst, $rose(out_valid), $past(state) == ST_READ, "result word without a read")
  `FEH_ASSERT_NOW(a_write_only_in_advance, clk, rst, wr_en, (state == ST_SEED) || (state == ST_RUN), "grid written outside an advance")
  `FEH_ASSERT_NEXT(a_frame_end_idle, clk, rst, (state == ST_RUN) && last_col && last_row, (state == ST_IDLE) && frame_done, "advance did not end in idle")

endmodule
